// ----- sv/dshot_frame_encoder_top_assert.svh -----
// ----------------------------------------------------------------------------
// DSHOT frame encoder assertion macros
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DSHOT_FRAME_ENCODER_TOP_ASSERT_SVH
`define DSHOT_FRAME_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while rst is high
`define DFE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while rst is high
`define DFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dfe_pkg.sv -----
// ----------------------------------------------------------------------------
// DSHOT frame encoder package
// Widths, register indexes, reset values, shared types and the frame builder.
// ----------------------------------------------------------------------------
package dfe_pkg;

  localparam int FRAME_BITS = 16;
  localparam int CNT_W      = $clog2(FRAME_BITS);
  localparam int CMD_BITS   = 11;
  localparam int CMD_IN_W   = 12;
  localparam int PULSE_W    = 16;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PULSE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COMMAND = 2'd2;

  localparam logic [PULSE_W-1:0]  RST_SHORT_PULSE = 16'd375;
  localparam logic [PULSE_W-1:0]  RST_LONG_PULSE  = 16'd750;
  localparam logic [CMD_BITS-1:0] RST_MAX_COMMAND = 11'd2047;

  typedef struct packed {
    logic [PULSE_W-1:0]  short_pulse_ticks;
    logic [PULSE_W-1:0]  long_pulse_ticks;
    logic [CMD_BITS-1:0] max_command;
  } cfg_t;

  // One symbol handed from the serializer to the output stage
  typedef struct packed {
    logic bit_value;
    logic last_bit;
    logic range_error;
  } sym_t;

  // Command bits, telemetry bit, then XOR of the three upper nibbles
  function automatic logic [FRAME_BITS-1:0] build_frame(
    input logic [CMD_BITS-1:0] cmd,
    input logic                tlm
  );
    logic [FRAME_BITS-1:0] f;
    logic [3:0]            chk;
    f   = {cmd, tlm, 4'h0};
    chk = f[7:4] ^ f[11:8] ^ f[15:12];
    return {f[FRAME_BITS-1:4], chk};
  endfunction

endpackage

// ----- sv/dfe_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// DSHOT configuration registers
// Holds pulse widths and the command limit; each accepted write is registered.
// ----------------------------------------------------------------------------
module dfe_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfe_pkg::CFG_DATA_W-1:0] cfg_data,
  output dfe_pkg::cfg_t                  cfg
);
  import dfe_pkg::*;

  assign cfg_ready = 1'b1;

  // Decode the index and update the addressed register; unknown index drops
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_pulse_ticks <= RST_SHORT_PULSE;
      cfg.long_pulse_ticks  <= RST_LONG_PULSE;
      cfg.max_command       <= RST_MAX_COMMAND;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SHORT_PULSE: cfg.short_pulse_ticks <= cfg_data;
        CFG_LONG_PULSE:  cfg.long_pulse_ticks  <= cfg_data;
        CFG_MAX_COMMAND: cfg.max_command       <= cfg_data[CMD_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/dfe_serializer.sv -----
// ----------------------------------------------------------------------------
// DSHOT frame serializer
// Builds the frame on accept and shifts it out one symbol per cycle while the output stage is ready.
// ----------------------------------------------------------------------------
module dfe_serializer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dfe_pkg::CMD_IN_W-1:0]  command_value,
  input  logic                          telemetry_request,
  input  logic [dfe_pkg::CMD_BITS-1:0]  max_command,
  output logic                          sym_valid,
  input  logic                          sym_ready,
  output dfe_pkg::sym_t                 sym
);
  import dfe_pkg::*;

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [FRAME_BITS-1:0] frame_sr;
  logic                  err;
  logic                  load;
  logic                  adv;
  logic                  last;

  assign last     = err || (cnt == CNT_W'(FRAME_BITS - 1));
  assign adv      = busy && sym_ready;
  assign in_ready = !busy || (adv && last);
  assign load     = in_valid && in_ready;

  assign sym_valid       = busy;
  assign sym.bit_value   = frame_sr[FRAME_BITS-1] && !err;
  assign sym.last_bit    = last;
  assign sym.range_error = err;

  // Track occupancy and bit position
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (adv) begin
      cnt <= cnt + 1'b1;
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  // Load a fresh frame or shift out the bit just taken
  always_ff @(posedge clk) begin
    if (load) begin
      frame_sr <= build_frame(command_value[CMD_BITS-1:0], telemetry_request);
      err      <= (command_value > {1'b0, max_command});
    end else if (adv) begin
      frame_sr <= {frame_sr[FRAME_BITS-2:0], 1'b0};
    end
  end

endmodule

// ----- sv/dfe_out_stage.sv -----
// ----------------------------------------------------------------------------
// DSHOT output stage
// Maps each symbol to its pulse width and holds it until the sink takes it.
// ----------------------------------------------------------------------------
module dfe_out_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sym_valid,
  output logic                      sym_ready,
  input  dfe_pkg::sym_t             sym,
  input  dfe_pkg::cfg_t             cfg,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [dfe_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tlast,
  output logic                      m_tuser
);
  import dfe_pkg::*;

  logic [PULSE_W-1:0] pulse_next;

  assign sym_ready = !m_tvalid || m_tready;

  // Pick the high time; an error item carries zero
  always_comb begin
    if (sym.range_error) begin
      pulse_next = '0;
    end else if (sym.bit_value) begin
      pulse_next = cfg.long_pulse_ticks;
    end else begin
      pulse_next = cfg.short_pulse_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (sym_ready) begin
      m_tvalid <= sym_valid;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (sym_ready && sym_valid) begin
      m_tdata <= {(OUT_W - PULSE_W - 1)'(0), sym.bit_value, pulse_next};
      m_tlast <= sym.last_bit;
      m_tuser <= sym.range_error;
    end
  end

endmodule

// ----- sv/dshot_frame_encoder_top.sv -----
// ----------------------------------------------------------------------------
// DSHOT frame encoder
// Turns a motor command into sixteen bit-pulse items or one error item.
// ----------------------------------------------------------------------------
// Input stream s_*: one item per command (command value, telemetry request).
// Output stream m_*: one item per frame bit, MSB first, carrying the high
// time in ticks and the bit; tlast marks the sixteenth bit. A command above
// max_command gives a single item with tuser set, zero width and tlast set.
// Config channel cfg_*: register index and data, always ready, one write per
// cycle; write only while the block is idle.
// The first item of a frame is registered in the serializer and then in the
// output register. The serializer shift register emits one bit per cycle
// while the sink does not stall. The next command is taken in the cycle the
// last bit leaves the serializer, so frames follow each other with no gap.
// Reset empties the serializer and output register and loads the default
// pulse widths (375 and 750 ticks) and limit (2047). When the sink stalls,
// the output item holds and the serializer and input side stall behind it.
// ----------------------------------------------------------------------------
module dshot_frame_encoder_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [11:0] command_value, [12] telemetry_request, [15:13] zero
  input  logic [dfe_pkg::IN_W-1:0]       s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [15:0] pulse_width, [16] bit_value, [23:17] zero
  output logic [dfe_pkg::OUT_W-1:0]      m_tdata,
  output logic                           m_tlast,
  // [0] range_error
  output logic                           m_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dfe_pkg::*;

  cfg_t cfg;
  sym_t sym;
  logic sym_valid;
  logic sym_ready;

  dfe_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dfe_serializer u_ser (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_tvalid),
    .in_ready          (s_tready),
    .command_value     (s_tdata[CMD_IN_W-1:0]),
    .telemetry_request (s_tdata[CMD_IN_W]),
    .max_command       (cfg.max_command),
    .sym_valid         (sym_valid),
    .sym_ready         (sym_ready),
    .sym               (sym)
  );

  dfe_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .sym_valid (sym_valid),
    .sym_ready (sym_ready),
    .sym       (sym),
    .cfg       (cfg),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

// ----- sv/dfe_checker.sv -----
// ----------------------------------------------------------------------------
// DSHOT frame encoder port checker
// Watches the output stream of the top level over time.
// ----------------------------------------------------------------------------
`include "dshot_frame_encoder_top_assert.svh"

module dfe_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [dfe_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tlast,
  input logic                      m_tuser
);

  // Stalled output item stays put
  `DFE_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output item changed while stalled")

  // Error item is alone: zero payload and closes the run
  `DFE_ASSERT_IMPLY(a_err_shape, clk, rst, m_tvalid && m_tuser, m_tlast && (m_tdata == '0), "error item has bad shape")

  // Reset leaves no output item pending
  `DFE_ASSERT_NEXT(a_rst_empty, clk, 1'b0, rst, !m_tvalid, "output valid right after reset")

endmodule

bind dshot_frame_encoder_top dfe_checker u_dfe_checker (.*);

// ----- tb/dshot_pulse_checker.sv -----
// ----------------------------------------------------------------------------
// DSHOT pulse checker
// Watches the configuration, command and pulse channels of the frame encoder.
// Keeps its own copy of the pulse-width and limit registers and turns every
// accepted command into the pulse items it must produce. Each accepted pulse
// item is then compared field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module dshot_pulse_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [dfe_pkg::IN_W-1:0]       s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [dfe_pkg::OUT_W-1:0]      m_tdata,
  input  logic                           m_tlast,
  input  logic                           m_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [dfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfe_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding
);

  import dfe_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [PULSE_W-1:0] width;
    logic               level;
    logic               last;
    logic               err;
  } pulse_t;

  // Register copy
  logic [PULSE_W-1:0]  short_ticks;
  logic [PULSE_W-1:0]  long_ticks;
  logic [CMD_BITS-1:0] cmd_limit;

  pulse_t expected_pulses[$];

  // Frame word: command, telemetry flag, then the nibble checksum
  function automatic logic [FRAME_BITS-1:0] dshot_word(
    input logic [CMD_BITS-1:0] cmd,
    input logic                tlm
  );
    logic [11:0] payload;
    logic [3:0]  csum;
    payload = {cmd, tlm};
    csum    = payload[3:0] ^ payload[7:4] ^ payload[11:8];
    return {payload, csum};
  endfunction

  // Queue the pulses one command must produce
  task automatic queue_frame_pulses(input logic [CMD_IN_W-1:0] cmd, input logic tlm);
    logic [FRAME_BITS-1:0] word;
    pulse_t                p;
    if (cmd > {1'b0, cmd_limit}) begin
      p = '{width: '0, level: 1'b0, last: 1'b1, err: 1'b1};
      expected_pulses.push_back(p);
    end else begin
      word = dshot_word(cmd[CMD_BITS-1:0], tlm);
      for (int k = FRAME_BITS - 1; k >= 0; k--) begin
        p.level = word[k];
        p.width = word[k] ? long_ticks : short_ticks;
        p.last  = (k == 0);
        p.err   = 1'b0;
        expected_pulses.push_back(p);
      end
    end
  endtask

  // Count a failure, report only the first few
  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%s", what);
    end
  endtask

  always @(posedge clk) begin
    pulse_t want;
    if (rst) begin
      short_ticks = RST_SHORT_PULSE;
      long_ticks  = RST_LONG_PULSE;
      cmd_limit   = RST_MAX_COMMAND;
      expected_pulses.delete();
    end else begin
      // Track register writes; an unknown index changes nothing
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SHORT_PULSE: short_ticks = cfg_data;
          CFG_LONG_PULSE:  long_ticks  = cfg_data;
          CFG_MAX_COMMAND: cmd_limit   = cfg_data[CMD_BITS-1:0];
          default: ;
        endcase
      end

      // Compare each pulse item with the oldest expected one
      if (m_tvalid && m_tready) begin
        if (expected_pulses.size() == 0) begin
          note_mismatch($sformatf(
            "unexpected pulse item: width %0d bit %0d last %0d err %0d pad %0h",
            m_tdata[15:0], m_tdata[16], m_tlast, m_tuser, m_tdata[OUT_W-1:17]));
        end else begin
          want = expected_pulses.pop_front();
          if (m_tdata[15:0] !== want.width || m_tdata[16] !== want.level ||
              m_tdata[OUT_W-1:17] !== '0 || m_tlast !== want.last ||
              m_tuser !== want.err) begin
            note_mismatch({
              $sformatf("pulse mismatch: want width %0d bit %0d last %0d err %0d, ",
                        want.width, want.level, want.last, want.err),
              $sformatf("got width %0d bit %0d last %0d err %0d pad %0h",
                        m_tdata[15:0], m_tdata[16], m_tlast, m_tuser,
                        m_tdata[OUT_W-1:17])});
          end
        end
      end

      // Predict pulses for an accepted command
      if (s_tvalid && s_tready) begin
        queue_frame_pulses(s_tdata[CMD_IN_W-1:0], s_tdata[CMD_IN_W]);
      end
    end
    outstanding = expected_pulses.size();
  end

endmodule

// ----- tb/dshot_frame_encoder_top_test.sv -----
// ----------------------------------------------------------------------------
// DSHOT frame encoder testbench
// Drives commands and register writes into the encoder with random gaps on
// both streams. A directed set covers field extremes, checksum patterns and
// out-of-range commands; random commands follow under several register
// settings, pulse widths at both ends among them. The checker predicts and
// compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module dshot_frame_encoder_top_test;

  import dfe_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 87;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tlast;
  logic                  m_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int                    mismatches;
  int                    outstanding;
  int                    quiet_cycles = 0;
  int                    rx_hold = 0;
  bit                    tx_steady = 1'b0;
  bit                    rx_steady = 1'b0;
  logic [CMD_BITS-1:0]   cur_limit = RST_MAX_COMMAND;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  dshot_frame_encoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dshot_pulse_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Gap length: mostly none, some short, a few long
  function automatic int pause_len(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly in-range commands, some anywhere, some on the limit edges
  function automatic logic [CMD_IN_W-1:0] pick_command(input logic [CMD_BITS-1:0] limit);
    int                  r;
    logic [CMD_IN_W-1:0] c;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      c = CMD_IN_W'($urandom_range(0, limit));
    end else if (r < 90) begin
      c = CMD_IN_W'($urandom_range(0, 4095));
    end else begin
      case ($urandom_range(0, 3))
        0:       c = '0;
        1:       c = {1'b0, limit};
        2:       c = {1'b0, limit} + 12'd1;
        default: c = '1;
      endcase
    end
    return c;
  endfunction

  // Sink side: random stalls, drive at the falling edge
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      m_tready <= 1'b0;
      rx_hold  <= rx_hold - 1;
    end else begin
      m_tready <= 1'b1;
      rx_hold  <= pause_len(rx_steady);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("dshot_frame_encoder_top_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one command item and hold it until accepted
  task automatic send_cmd(input logic [CMD_IN_W-1:0] cmd, input logic tlm);
    int gap;
    gap = pause_len(tx_steady);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, tlm, cmd};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Drain the encoder, then load all registers plus a write to the spare index
  task automatic program_regs(
    input logic [CFG_DATA_W-1:0] short_w,
    input logic [CFG_DATA_W-1:0] long_w,
    input logic [CFG_DATA_W-1:0] limit_w
  );
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_write(CFG_SHORT_PULSE, short_w);
    cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_write(CFG_LONG_PULSE, long_w);
    cfg_write(CFG_MAX_COMMAND, limit_w);
    cfg_valid <= 1'b0;
    cur_limit = limit_w[CMD_BITS-1:0];
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      // Switch between gappy and back-to-back stretches
      if (i % 30 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      send_cmd(pick_command(cur_limit), 1'($urandom_range(0, 1)));
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] w;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: extremes, checksum patterns, out-of-range commands
    send_cmd(12'd0, 1'b0);
    send_cmd(12'd0, 1'b1);
    send_cmd(12'd2047, 1'b0);
    send_cmd(12'd2047, 1'b1);
    send_cmd(12'd1, 1'b0);
    send_cmd(12'd1024, 1'b1);
    send_cmd(12'h555, 1'b0);
    send_cmd(12'h2AA, 1'b1);
    send_cmd(12'h0F0, 1'b1);
    send_cmd(12'h70F, 1'b0);
    send_cmd(12'd2048, 1'b0);
    send_cmd(12'd4095, 1'b1);
    send_cmd(12'hAAA, 1'b0);
    run_random(PHASE_ITEMS);

    // Zero-width short pulse, full-scale long pulse, limit from oversized data
    program_regs(16'h0000, 16'hFFFF, 16'hFFFF);
    send_cmd(12'd2047, 1'b1);
    send_cmd(12'd0, 1'b0);
    send_cmd(12'd2048, 1'b1);
    run_random(PHASE_ITEMS);

    // Swapped extremes, limit of zero
    program_regs(16'hFFFF, 16'h0000, 16'hF800);
    send_cmd(12'd0, 1'b1);
    send_cmd(12'd1, 1'b0);
    send_cmd(12'd0, 1'b0);
    run_random(PHASE_ITEMS);

    // Random widths and limit
    program_regs(CFG_DATA_W'($urandom_range(0, 65535)),
                 CFG_DATA_W'($urandom_range(0, 65535)),
                 CFG_DATA_W'($urandom_range(0, 65535)));
    send_cmd({1'b0, cur_limit}, 1'b0);
    send_cmd({1'b0, cur_limit} + 12'd1, 1'b1);
    run_random(PHASE_ITEMS);

    // Equal widths, mid-range limit with junk in the upper data bits
    w = CFG_DATA_W'($urandom_range(0, 65535));
    program_regs(w, w, {5'b10101, 11'd1000});
    send_cmd(12'd1000, 1'b1);
    send_cmd(12'd1001, 1'b0);
    run_random(PHASE_ITEMS + 16);

    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("dshot_frame_encoder_top_test OK");
    end else begin
      $display("dshot_frame_encoder_top_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/dfe_pkg.sv
sv/dfe_cfg_regs.sv
sv/dfe_serializer.sv
sv/dfe_out_stage.sv
sv/dshot_frame_encoder_top.sv
sv/dfe_checker.sv
tb/dshot_pulse_checker.sv
tb/dshot_frame_encoder_top_test.sv
